// ===== rtl/scrolling_led_matrix_scanner_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scrolling LED matrix scanner
// Clocked on clk_i and disabled while rst_ni is low; define ASSERT_OFF to drop.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_LED_MATRIX_SCANNER_CORE_ASSERT_SVH
`define SCROLLING_LED_MATRIX_SCANNER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define SLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true outside reset
`define SLMS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SLMS_ASSERT(lbl, prop, msg)
`define SLMS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/slms_pkg.sv =====
// ----------------------------------------------------------------------------
// slms_pkg
// Shared types and constants of the scrolling LED matrix scanner.
// ----------------------------------------------------------------------------
package slms_pkg;

  // Field widths
  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned ROW_W        = 3;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned ROWS         = 8;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned SLOT_CNT_W   = 9;   // holds any slot count up to 256

  // Default glyph slot count
  localparam int unsigned SLOTS_DEFAULT = 64;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SLOT     = 2'd1;

  // Register reset values and counter limits
  localparam logic [PERIOD_W-1:0]     PERIOD_RESET    = 16'd500;
  localparam logic [SLOT_FIELD_W-1:0] LAST_SLOT_RESET = 6'd11;
  localparam logic [PERIOD_W-1:0]     ELAPSED_MAX     = 16'hFFFF;
  localparam logic [ROW_W-1:0]        SHIFT_LAST      = 3'd7;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_e;

  // One classified input item
  typedef struct packed {
    item_kind_e              kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ROW_W-1:0]        row;
    logic [PIX_W-1:0]        pattern;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

// ===== rtl/slms_ram.sv =====
// ----------------------------------------------------------------------------
// slms_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module slms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/slms_front.sv =====
// ----------------------------------------------------------------------------
// slms_front
// Accepts input items, classifies them as load or tick and queues them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`include "scrolling_led_matrix_scanner_core_assert.svh"

module slms_front import slms_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [SLOT_FIELD_W-1:0] slot_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [PIX_W-1:0]        pattern_i,
  input  logic                    pop_i,
  output head_t                   head_o
);

  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  // Classify the incoming item
  always_comb begin
    in_cmd.kind    = item_kind_e'(kind_i);
    in_cmd.slot    = slot_i;
    in_cmd.row     = row_i;
    in_cmd.pattern = pattern_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the queued item
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_cmd;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = q_mem_q[rd_ptr_q];

  `SLMS_ASSERT_NEVER(a_cnt_range, cnt_q == 2'd3, "queue count out of range")
  `SLMS_ASSERT(a_full_no_push, cnt_q == 2'd2 |-> !push, "push into full queue")

endmodule

// ===== rtl/slms_back.sv =====
// ----------------------------------------------------------------------------
// slms_back
// Carries out queued items: writes glyph rows, counts ticks, rebuilds the
// scrolled frame and emits one scan row per tick through an output register.
// ----------------------------------------------------------------------------
`include "scrolling_led_matrix_scanner_core_assert.svh"

module slms_back import slms_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  head_t                 head_i,
  output logic                  pop_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      row_select_o,
  output logic [PIX_W-1:0]      row_pixels_o,
  output logic [ROW_W-1:0]      scan_index_o
);

  localparam int unsigned             SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_CNT_W-1:0]   SLOTS_L = SLOT_CNT_W'(SLOTS);

  // Configuration registers
  logic [PERIOD_W-1:0]     period_q;
  logic [SLOT_FIELD_W-1:0] last_slot_q;

  // Scroll and scan state
  logic [PERIOD_W-1:0]     elapsed_q, elapsed_d, elapsed_inc;
  logic [ROW_W-1:0]        shift_q, shift_d;
  logic [SLOT_FIELD_W-1:0] slot_idx_q, slot_idx_d;
  logic [ROW_W-1:0]        scan_q, scan_d;
  logic [SLOTS-1:0]        slot_vld_q, slot_vld_d;
  logic [PIX_W-1:0]        frame_q [ROWS];
  logic [PIX_W-1:0]        frame_d [ROWS];

  // Second stage of a tick
  logic             s2_valid_q;
  logic             s2_scroll_q;
  logic [ROW_W-1:0] s2_shift_q;
  logic [ROW_W-1:0] s2_scan_q;
  logic             s2_cur_ok_q;
  logic             s2_nxt_ok_q;

  // Output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_sel_q, out_pix_q;
  logic [ROW_W-1:0] out_scan_q;

  logic                    out_free;
  logic                    s2_adv;
  logic                    tick_go;
  logic                    load_go;
  logic                    load_wr;
  logic                    scroll;
  logic [SLOT_FIELD_W:0]   nxt_slot;
  logic                    cur_in_range;
  logic                    nxt_in_range;
  logic                    ld_in_range;
  logic [SLOT_W-1:0]       cur_addr, nxt_addr, ld_addr;
  logic                    ld_vld;
  logic [ROWS-1:0]         ram_we;
  logic [PIX_W-1:0]        ram_wdata [ROWS];
  logic [PIX_W-1:0]        rd_cur [ROWS];
  logic [PIX_W-1:0]        rd_nxt [ROWS];
  logic [PIX_W-1:0]        new_row [ROWS];
  logic [PIX_W-1:0]        pix;

  // Handshake between stages
  assign out_free = !out_valid_q || out_ready_i;
  assign s2_adv   = s2_valid_q && out_free;
  assign tick_go  = head_i.valid && (head_i.cmd.kind == KIND_TICK) &&
                    (!s2_valid_q || out_free);
  assign load_go  = head_i.valid && (head_i.cmd.kind == KIND_LOAD);
  assign pop_o    = tick_go || load_go;

  // Load addressing; slots past the store are dropped
  assign ld_in_range = (SLOT_CNT_W'(head_i.cmd.slot) < SLOTS_L);
  assign ld_addr     = SLOT_W'(head_i.cmd.slot);
  assign ld_vld      = ld_in_range && slot_vld_q[ld_addr];
  assign load_wr     = load_go && ld_in_range;

  // First write to a slot zeroes its other rows as well
  always_comb begin
    slot_vld_d = slot_vld_q;
    if (load_wr) begin
      slot_vld_d[ld_addr] = 1'b1;
    end
    for (int r = 0; r < ROWS; r++) begin
      ram_we[r]    = load_wr && (!ld_vld || (head_i.cmd.row == ROW_W'(r)));
      ram_wdata[r] = (head_i.cmd.row == ROW_W'(r)) ? head_i.cmd.pattern : '0;
    end
  end

  // Tick: count time, decide on a scroll step, advance column and slot
  assign nxt_slot     = {1'b0, slot_idx_q} + 7'd1;
  assign cur_in_range = (SLOT_CNT_W'(slot_idx_q) < SLOTS_L);
  assign nxt_in_range = (SLOT_CNT_W'(nxt_slot) < SLOTS_L);
  assign cur_addr     = SLOT_W'(slot_idx_q);
  assign nxt_addr     = SLOT_W'(nxt_slot);
  assign elapsed_inc  = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
  assign scroll       = (elapsed_inc >= period_q);

  always_comb begin
    elapsed_d  = elapsed_q;
    shift_d    = shift_q;
    slot_idx_d = slot_idx_q;
    scan_d     = scan_q;
    if (tick_go) begin
      elapsed_d = scroll ? '0 : elapsed_inc;
      scan_d    = scan_q + 3'd1;
      if (scroll) begin
        shift_d = shift_q + 3'd1;
        if (shift_q == SHIFT_LAST) begin
          slot_idx_d = (slot_idx_q == last_slot_q) ? '0 : slot_idx_q + 6'd1;
        end
      end
    end
  end

  // Glyph store: one RAM per glyph row
  for (genvar gr = 0; gr < ROWS; gr++) begin : g_row_ram
    slms_ram #(
      .WIDTH (PIX_W),
      .DEPTH (SLOTS)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (ram_we[gr]),
      .waddr_i   (ld_addr),
      .wdata_i   (ram_wdata[gr]),
      .re_i      (tick_go),
      .raddr_a_i (cur_addr),
      .raddr_b_i (nxt_addr),
      .rdata_a_o (rd_cur[gr]),
      .rdata_b_o (rd_nxt[gr])
    );
  end

  // Stage two: merge current and next glyph into the shifted frame
  always_comb begin
    logic [2*PIX_W-1:0] cur_w;
    logic [2*PIX_W-1:0] nxt_w;
    logic [2*PIX_W-1:0] mix;
    for (int r = 0; r < ROWS; r++) begin
      cur_w      = {8'd0, (s2_cur_ok_q ? rd_cur[r] : 8'd0)};
      nxt_w      = {8'd0, (s2_nxt_ok_q ? rd_nxt[r] : 8'd0)};
      mix        = (cur_w >> s2_shift_q) | (nxt_w << (4'd8 - {1'b0, s2_shift_q}));
      new_row[r] = mix[PIX_W-1:0];
      frame_d[r] = (s2_adv && s2_scroll_q) ? new_row[r] : frame_q[r];
    end
  end

  assign pix = s2_scroll_q ? new_row[s2_scan_q] : frame_q[s2_scan_q];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      last_slot_q <= LAST_SLOT_RESET;
      elapsed_q   <= '0;
      shift_q     <= '0;
      slot_idx_q  <= '0;
      scan_q      <= '0;
      slot_vld_q  <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        frame_q[r] <= '0;
      end
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_SCROLL_PERIOD)) begin
        period_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_LAST_SLOT)) begin
        last_slot_q <= cfg_wdata_i[SLOT_FIELD_W-1:0];
      end
      elapsed_q  <= elapsed_d;
      shift_q    <= shift_d;
      slot_idx_q <= slot_idx_d;
      scan_q     <= scan_d;
      slot_vld_q <= slot_vld_d;
      for (int r = 0; r < ROWS; r++) begin
        frame_q[r] <= frame_d[r];
      end
      if (tick_go) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage two payload
  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      s2_scroll_q <= scroll;
      s2_shift_q  <= shift_q;
      s2_scan_q   <= scan_q;
      s2_cur_ok_q <= cur_in_range && slot_vld_q[cur_addr];
      s2_nxt_ok_q <= nxt_in_range && slot_vld_q[nxt_addr];
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_sel_q  <= ~(8'd1 << s2_scan_q);
      out_pix_q  <= pix;
      out_scan_q <= s2_scan_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_select_o = out_sel_q;
  assign row_pixels_o = out_pix_q;
  assign scan_index_o = out_scan_q;

  `SLMS_ASSERT(a_no_issue_stall, (s2_valid_q && !out_free) |-> !tick_go, "tick issued into stalled stage")
  `SLMS_ASSERT(a_s2_hold, (s2_valid_q && !out_free) |=> (s2_valid_q && $stable(s2_scan_q)), "stage two lost while stalled")
  `SLMS_ASSERT(a_shift_step, (tick_go && scroll) |=> (shift_q == $past(shift_q) + 3'd1), "column did not advance on scroll")
  `SLMS_ASSERT(a_scan_step, tick_go |=> (scan_q == $past(scan_q) + 3'd1), "scan row did not advance on tick")

endmodule

// ===== rtl/scrolling_led_matrix_scanner_core.sv =====
// ----------------------------------------------------------------------------
// scrolling_led_matrix_scanner_core
// Scrolling 8x8 LED matrix scanner: glyph store, scroll timer and row scan.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_ready_o. A load item (kind_i = 0)
// writes pattern_i into row row_i of glyph slot slot_i and gives no result.
// A tick item (kind_i = 1) counts one millisecond, rebuilds the scrolled frame
// once scroll_period_ms ticks have passed, and gives one scan row result on
// out_valid_o/out_ready_i: row_select_o (active low), row_pixels_o and
// scan_index_o. Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while no item is in flight: index 0 is the scroll period, index 1 the last
// glyph slot.
// Throughput: one item per cycle while the receiver does not stall. A tick
// result passes through the item queue and the registered glyph store read,
// then through the frame merge into the output register.
// Reset clears the glyph store (per-slot valid bits), the frame, the counters
// and the output; the block takes items from the first cycle after reset.
// When the receiver stalls, the result is held, loads ahead of the next tick
// still drain, that tick and the items behind it wait in the two-entry queue,
// and in_ready_o drops once it is full.
// ----------------------------------------------------------------------------
module scrolling_led_matrix_scanner_core import slms_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [SLOT_FIELD_W-1:0] slot_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [PIX_W-1:0]        pattern_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PIX_W-1:0]        row_select_o,
  output logic [PIX_W-1:0]        row_pixels_o,
  output logic [ROW_W-1:0]        scan_index_o
);

  head_t head;
  logic  pop;

  // Accept and classify items
  slms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .slot_i     (slot_i),
    .row_i      (row_i),
    .pattern_i  (pattern_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  // Execute loads and ticks
  slms_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_select_o (row_select_o),
    .row_pixels_o (row_pixels_o),
    .scan_index_o (scan_index_o)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Scrolling LED matrix scanner testbench
// Loads glyph rows and sends millisecond ticks through the item handshake.
// An in-bench scan model predicts every scan row, and each received row is
// checked field by field. The run covers several scroll periods and slot
// counts, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import slms_pkg::*; ;

  // One expected scan row
  typedef struct packed {
    logic [PIX_W-1:0] sel_n;
    logic [PIX_W-1:0] pixels;
    logic [ROW_W-1:0] index;
  } scan_row_t;

  // Scan model plus queue of rows still owed by the block
  class scan_checker;
    logic [PIX_W-1:0]        glyph_rows [SLOTS_DEFAULT][ROWS];
    logic [PIX_W-1:0]        frame_rows [ROWS];
    logic [ROW_W-1:0]        col_shift;
    logic [SLOT_FIELD_W-1:0] cur_slot;
    logic [PERIOD_W-1:0]     ms_count;
    logic [ROW_W-1:0]        scan_ptr;
    logic [PERIOD_W-1:0]     period;
    logic [SLOT_FIELD_W-1:0] final_slot;
    scan_row_t               expected_scans [$];
    int unsigned             errors;

    function new();
      foreach (glyph_rows[s, r]) glyph_rows[s][r] = '0;
      foreach (frame_rows[r]) frame_rows[r] = '0;
      col_shift  = '0;
      cur_slot   = '0;
      ms_count   = '0;
      scan_ptr   = '0;
      period     = PERIOD_RESET;
      final_slot = LAST_SLOT_RESET;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCROLL_PERIOD: period = data[PERIOD_W-1:0];
        CFG_LAST_SLOT:     final_slot = data[SLOT_FIELD_W-1:0];
        default: ;
      endcase
    endfunction

    // Slots past the store read as blank
    function logic [PIX_W-1:0] glyph_at(int unsigned s, int unsigned r);
      if (s >= SLOTS_DEFAULT) return '0;
      return glyph_rows[s][r];
    endfunction

    // Rebuild the frame one column further, then advance column and slot
    function void scroll_frame();
      logic [2*PIX_W-1:0] merged;
      for (int r = 0; r < ROWS; r++) begin
        merged = ({{PIX_W{1'b0}}, glyph_at(int'(cur_slot), r)} >> col_shift)
               | ({{PIX_W{1'b0}}, glyph_at(int'(cur_slot) + 1, r)} << (PIX_W - col_shift));
        frame_rows[r] = merged[PIX_W-1:0];
      end
      col_shift = col_shift + 1'b1;
      if (col_shift == '0) begin
        if (cur_slot == final_slot) cur_slot = '0;
        else cur_slot = cur_slot + 1'b1;
      end
    endfunction

    function void take_item(item_kind_e kind, logic [SLOT_FIELD_W-1:0] slot,
                            logic [ROW_W-1:0] row, logic [PIX_W-1:0] pattern);
      scan_row_t exp_row;
      if (kind == KIND_LOAD) begin
        if (slot < SLOTS_DEFAULT) glyph_rows[slot][row] = pattern;
        return;
      end
      // Count the tick, saturating, and scroll once the period is reached
      if (ms_count != ELAPSED_MAX) ms_count = ms_count + 1'b1;
      if (ms_count >= period) begin
        ms_count = '0;
        scroll_frame();
      end
      exp_row.sel_n  = ~(PIX_W'(1) << scan_ptr);
      exp_row.pixels = frame_rows[scan_ptr];
      exp_row.index  = scan_ptr;
      scan_ptr = scan_ptr + 1'b1;
      expected_scans.push_back(exp_row);
    endfunction

    function void check_scan(logic [PIX_W-1:0] sel_n, logic [PIX_W-1:0] pixels,
                             logic [ROW_W-1:0] index);
      scan_row_t exp_row;
      if (expected_scans.size() == 0) begin
        $error("unexpected scan row: row_select %h row_pixels %h scan_index %0d",
               sel_n, pixels, index);
        errors++;
        return;
      end
      exp_row = expected_scans.pop_front();
      if (sel_n !== exp_row.sel_n) begin
        $error("row_select: expected %h, actual %h", exp_row.sel_n, sel_n);
        errors++;
      end
      if (pixels !== exp_row.pixels) begin
        $error("row_pixels: expected %h, actual %h", exp_row.pixels, pixels);
        errors++;
      end
      if (index !== exp_row.index) begin
        $error("scan_index: expected %0d, actual %0d", exp_row.index, index);
        errors++;
      end
    endfunction
  endclass

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 35;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  item_kind_e              kind_i      = KIND_LOAD;
  logic [SLOT_FIELD_W-1:0] slot_i      = '0;
  logic [ROW_W-1:0]        row_i       = '0;
  logic [PIX_W-1:0]        pattern_i   = '0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [PIX_W-1:0]        row_select_o;
  logic [PIX_W-1:0]        row_pixels_o;
  logic [ROW_W-1:0]        scan_index_o;

  int unsigned src_gap_pct    = 6;
  int unsigned sink_stall_pct = 46;
  scan_checker scans;

  scrolling_led_matrix_scanner_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .slot_i       (slot_i),
    .row_i        (row_i),
    .pattern_i    (pattern_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_select_o (row_select_o),
    .row_pixels_o (row_pixels_o),
    .scan_index_o (scan_index_o)
  );

  always #10 clk_i = ~clk_i;

  // Stall the receiver at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Note accepted items and check accepted scan rows
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) scans.take_item(kind_i, slot_i, row_i, pattern_i);
      if (out_valid_o && out_ready_i) scans.check_scan(row_select_o, row_pixels_o, scan_index_o);
    end
  end

  // Offer one item, with random gaps first; call and return at a falling edge
  task automatic send_item(item_kind_e kind, logic [SLOT_FIELD_W-1:0] slot,
                           logic [ROW_W-1:0] row, logic [PIX_W-1:0] pattern);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    slot_i     <= slot;
    row_i      <= row;
    pattern_i  <= pattern;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, SLOT_FIELD_W'($urandom), ROW_W'($urandom), PIX_W'($urandom));
  endtask

  // Mostly loads into the slots in play and ticks, with some stray loads
  task automatic send_random_item(logic [SLOT_FIELD_W-1:0] top_slot);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      send_item(KIND_LOAD, SLOT_FIELD_W'($urandom_range(0, int'(top_slot) + 1)),
                ROW_W'($urandom), PIX_W'($urandom));
    else if (pick < 38)
      send_item(KIND_LOAD, SLOT_FIELD_W'($urandom), ROW_W'($urandom), PIX_W'($urandom));
    else
      send_tick();
  endtask

  // Drop valid, wait for every owed row, then let loads in flight retire
  task automatic settle();
    in_valid_i <= 1'b0;
    while (scans.expected_scans.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    scans.write_reg(idx, data);
  endtask

  initial begin
    logic [PERIOD_W-1:0]     period_val;
    logic [SLOT_FIELD_W-1:0] last_val;
    scans = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Blank first frame under the reset settings
    send_item(KIND_LOAD, 6'd63, 3'd7, 8'hFF);
    send_item(KIND_LOAD, 6'd0, 3'd0, 8'h00);
    send_item(KIND_LOAD, 6'd1, 3'd0, 8'h80);
    send_item(KIND_LOAD, 6'd1, 3'd4, 8'h01);
    repeat (3) send_tick();
    settle();

    // Scroll on every tick with a single slot; unused indexes must be ignored
    write_reg(CFG_SCROLL_PERIOD, 16'd0);
    write_reg(CFG_LAST_SLOT, 16'd0);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h5A5A);
    send_item(KIND_LOAD, 6'd0, 3'd0, 8'h81);
    send_item(KIND_LOAD, 6'd1, 3'd3, 8'hFF);
    send_item(KIND_LOAD, 6'd1, 3'd7, 8'h55);
    send_item(KIND_LOAD, 6'd2, 3'd2, 8'h3C);
    repeat (14) send_tick();

    // Random phases, each with its own period and slot count
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p < 4) begin
        src_gap_pct    = 6;
        sink_stall_pct = 46;
      end else if (p < 8) begin
        src_gap_pct    = 46;
        sink_stall_pct = 6;
      end else begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      case ($urandom_range(0, 7))
        0:       period_val = '0;
        1, 2, 3: period_val = 16'd1;
        4:       period_val = 16'd2;
        5:       period_val = 16'd3;
        6:       period_val = PERIOD_W'($urandom_range(4, 12));
        default: period_val = PERIOD_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       last_val = '0;
        1:       last_val = 6'd1;
        2:       last_val = SLOT_FIELD_W'($urandom_range(2, 4));
        3:       last_val = SLOT_FIELD_W'($urandom_range(1, 62));
        4:       last_val = 6'd63;
        default: last_val = SLOT_FIELD_W'($urandom_range(5, 10));
      endcase
      write_reg(CFG_SCROLL_PERIOD, period_val);
      // Upper data bits are don't-care for the slot count
      write_reg(CFG_LAST_SLOT, {10'($urandom), last_val});
      repeat (PHASE_ITEMS) send_random_item(last_val);
    end

    settle();
    if (scans.errors == 0 && scans.expected_scans.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
